// ===== rtl/bfba_pkg.sv =====
`default_nettype none
package bfba_pkg;
  localparam int FLOW_ENTRIES_DEF = 32;
  localparam int ADDR_W = 32;
  localparam int CNT_W = 32;
  localparam int LEN_W = 16;
  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic [LEN_W-1:0]  pkt_length;
  } in_item_t;

  typedef struct packed {
    logic             flow_valid;
    logic [ADDR_W-1:0] flow_src;
    logic [ADDR_W-1:0] flow_dst;
    logic [CNT_W-1:0]  fwd_bytes;
    logic [CNT_W-1:0]  rev_bytes;
    logic [CNT_W-1:0]  in_total;
    logic [CNT_W-1:0]  out_total;
    logic             table_overflow;
    logic             last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PKT,
    ST_SORT,
    ST_EMIT
  } back_state_t;

  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== rtl/bfba_front.sv =====
`default_nettype none
module bfba_front
  import bfba_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire in_item_t in_item,
  input  wire logic     in_valid,
  output logic          in_ready,
  output in_item_t      q_item,
  output logic          q_valid,
  input  wire logic     q_ready
);
  // Two-entry queue between intake and the table engine.
  in_item_t   mem [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       push, pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = mem[rptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_item;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/bfba_back.sv =====
`default_nettype none
module bfba_back
  import bfba_pkg::*;
#(
  parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [ADDR_W-1:0] local_addr,
  input  wire in_item_t          q_item,
  input  wire logic              q_valid,
  output logic                   q_ready,
  output out_item_t              res,
  output logic                   res_valid,
  input  wire logic              res_ready
);
  localparam int IW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int UW = $clog2(FLOW_ENTRIES + 1);
  localparam int P  = 1 << IW;

  logic [ADDR_W-1:0] fsrc [FLOW_ENTRIES];
  logic [ADDR_W-1:0] fdst [FLOW_ENTRIES];
  logic [CNT_W-1:0]  ffwd [FLOW_ENTRIES];
  logic [CNT_W-1:0]  frev [FLOW_ENTRIES];
  logic [FLOW_ENTRIES-1:0] done;
  logic [UW-1:0]     used;
  logic [CNT_W-1:0]  bin, bout;
  logic              ovf;
  back_state_t       state, state_next;
  in_item_t          cur;
  logic [FLOW_ENTRIES-1:0] mf, mr;
  logic [IW-1:0]     hit_idx;
  logic              hit_any, hit_fwd;
  logic [UW-1:0]     emitted;
  logic [IW-1:0]     best;
  logic              emit_now;
  logic              nd_ok  [1:2*P-1];
  logic [IW-1:0]     nd_idx [1:2*P-1];
  logic [CNT_W-1:0]  nd_cnt [1:2*P-1];

  // Forward/reverse match, first matching entry wins.
  always_comb begin
    for (int i = 0; i < FLOW_ENTRIES; i++) begin
      mf[i] = (i < used) && fsrc[i] == cur.src_addr && fdst[i] == cur.dst_addr;
      mr[i] = (i < used) && fsrc[i] == cur.dst_addr && fdst[i] == cur.src_addr;
    end
    hit_any = 1'b0;
    hit_fwd = 1'b0;
    hit_idx = '0;
    for (int i = FLOW_ENTRIES - 1; i >= 0; i--) begin
      if (mf[i] || mr[i]) begin
        hit_any = 1'b1;
        hit_fwd = mf[i];
        hit_idx = IW'(i);
      end
    end
  end

  // Selection: largest forward count among unsent entries, latest on ties.
  for (genvar g = 0; g < P; g++) begin : g_leaf
    if (g < FLOW_ENTRIES) begin : g_entry
      assign nd_ok[P+g]  = (UW'(g) < used) && !done[g];
      assign nd_cnt[P+g] = ffwd[g];
    end else begin : g_pad
      assign nd_ok[P+g]  = 1'b0;
      assign nd_cnt[P+g] = '0;
    end
    assign nd_idx[P+g] = IW'(g);
  end

  for (genvar n = 1; n < P; n++) begin : g_node
    logic take_r;
    assign take_r    = nd_ok[2*n+1] && (!nd_ok[2*n] || nd_cnt[2*n+1] >= nd_cnt[2*n]);
    assign nd_ok[n]  = nd_ok[2*n] || nd_ok[2*n+1];
    assign nd_idx[n] = take_r ? nd_idx[2*n+1] : nd_idx[2*n];
    assign nd_cnt[n] = take_r ? nd_cnt[2*n+1] : nd_cnt[2*n];
  end

  assign best = nd_idx[1];

  assign q_ready  = (state == ST_IDLE);
  assign emit_now = (state == ST_EMIT) && (!res_valid || res_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (q_valid) state_next = (q_item.opcode == OP_TICK) ? ST_SORT : ST_PKT;
      ST_PKT:  state_next = ST_IDLE;
      ST_SORT: state_next = ST_EMIT;
      ST_EMIT: if (emit_now && (used == '0 || emitted + 1'b1 == used)) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) cur <= q_item;
    if (state == ST_PKT) begin
      if (hit_any) begin
        if (hit_fwd) ffwd[hit_idx] <= sat_add(ffwd[hit_idx], CNT_W'(cur.pkt_length));
        else frev[hit_idx] <= sat_add(frev[hit_idx], CNT_W'(cur.pkt_length));
      end else if (used < UW'(FLOW_ENTRIES)) begin
        fsrc[used[IW-1:0]] <= cur.src_addr;
        fdst[used[IW-1:0]] <= cur.dst_addr;
        ffwd[used[IW-1:0]] <= CNT_W'(cur.pkt_length);
        frev[used[IW-1:0]] <= '0;
      end
    end
    if (emit_now) begin
      res.flow_valid     <= (used != '0);
      res.flow_src       <= (used != '0) ? fsrc[best] : '0;
      res.flow_dst       <= (used != '0) ? fdst[best] : '0;
      res.fwd_bytes      <= (used != '0) ? ffwd[best] : '0;
      res.rev_bytes      <= (used != '0) ? frev[best] : '0;
      res.in_total       <= bin;
      res.out_total      <= bout;
      res.table_overflow <= ovf;
      res.last           <= (used == '0) || (emitted + 1'b1 == used);
    end
    if (rst) begin
      state     <= ST_IDLE;
      used      <= '0;
      bin       <= '0;
      bout      <= '0;
      ovf       <= 1'b0;
      done      <= '0;
      emitted   <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= emit_now || (res_valid && !res_ready);
      unique case (state)
        ST_PKT: begin
          if (cur.src_addr == local_addr) bout <= sat_add(bout, CNT_W'(cur.pkt_length));
          else bin <= sat_add(bin, CNT_W'(cur.pkt_length));
          if (!hit_any) begin
            if (used < UW'(FLOW_ENTRIES)) used <= used + 1'b1;
            else ovf <= 1'b1;
          end
        end
        ST_SORT: begin
          done    <= '0;
          emitted <= '0;
        end
        ST_EMIT: begin
          if (emit_now) begin
            done[best] <= 1'b1;
            emitted    <= emitted + 1'b1;
            if (state_next == ST_IDLE) begin
              used <= '0;
              bin  <= '0;
              bout <= '0;
              ovf  <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/bidirectional_flow_byte_accounting.sv =====
// A packet item is taken from the queue in the idle state, then matched against every entry
// in parallel in the packet state, where the table is updated.
// A tick is taken in the idle state and set up in the sort state, then reports one result per
// cycle while the receiver is ready; its first result is registered in the emit state.
// A two-entry queue decouples intake from the engine. Synchronous active-high reset empties
// the table and clears the totals, the overflow flag and local_addr.
`default_nettype none
module bidirectional_flow_byte_accounting
  import bfba_pkg::*;
#(
  parameter int FLOW_ENTRIES = FLOW_ENTRIES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [ADDR_W-1:0] cfg_data,
  input  wire in_item_t          in_item,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output out_item_t              out_item,
  output logic                   out_valid,
  input  wire logic              out_ready
);
  logic [ADDR_W-1:0] local_addr;
  in_item_t          q_item;
  logic              q_valid, q_ready;

  always_ff @(posedge clk) begin
    if (rst) local_addr <= '0;
    else if (cfg_we) local_addr <= cfg_data;
  end

  bfba_front u_front (
    .clk, .rst, .in_item, .in_valid, .in_ready, .q_item, .q_valid, .q_ready
  );

  bfba_back #(.FLOW_ENTRIES(FLOW_ENTRIES)) u_back (
    .clk, .rst, .local_addr, .q_item, .q_valid, .q_ready,
    .res(out_item), .res_valid(out_valid), .res_ready(out_ready)
  );
endmodule
`default_nettype wire
